/* rtl/g2fb_pkg.sv */
// Shared constants, types and helper functions of the 2-bit grayscale frame store engine.
`timescale 1ns / 1ps

package g2fb_pkg;

  // Screen geometry and store layout.
  localparam int COLUMNS       = 138;
  localparam int ROWS          = 110;
  localparam int WORDS_PER_ROW = 18;
  localparam int STORE_DEPTH   = WORDS_PER_ROW * ROWS;

  // Widths of the item fields.
  localparam int OP_W    = 2;
  localparam int COORD_W = 10;
  localparam int SPAN_W  = 9;
  localparam int GRAY_W  = 2;

  // Word layout: eight 2-bit pixels per 16-bit word.
  localparam int WORD_W    = 16;
  localparam int PIX_PER_W = 8;
  localparam int PSEL_W    = 3;

  // Internal widths.
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_W  = $clog2(STORE_DEPTH + 128);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EXT_W  = COORD_W + 2;
  localparam int WX_W   = SPAN_W - PSEL_W;

  // Clipping limits.
  localparam logic signed [COORD_W-1:0] COL_LIM = COORD_W'(COLUMNS);
  localparam logic signed [COORD_W-1:0] ROW_LIM = COORD_W'(ROWS);
  localparam logic signed [EXT_W-1:0]   COL_MAX = EXT_W'(COLUMNS - 1);
  localparam logic signed [EXT_W-1:0]   ROW_MAX = EXT_W'(ROWS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FILL  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  // Bit mask that covers pixels lo through hi of one word.
  function automatic logic [WORD_W-1:0] span_mask(input logic [PSEL_W-1:0] lo,
                                                  input logic [PSEL_W-1:0] hi);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int p = 0; p < PIX_PER_W; p++) begin
      if ((PSEL_W'(p) >= lo) && (PSEL_W'(p) <= hi)) begin
        m[2*p +: 2] = 2'b11;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/g2fb_cmd_if.sv */
// Command channel: valid/ready handshake with one pixel engine command as payload.
`timescale 1ns / 1ps

interface g2fb_cmd_if;
  import g2fb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [SPAN_W-1:0]         box_width;
  logic [SPAN_W-1:0]         box_height;
  logic [GRAY_W-1:0]         gray_level;

  modport source (output valid, opcode, pos_x, pos_y, box_width, box_height, gray_level,
                  input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, box_width, box_height, gray_level,
                  output ready);
endinterface

/* rtl/g2fb_res_if.sv */
// Result channel: valid/ready handshake with one command result as payload.
`timescale 1ns / 1ps

interface g2fb_res_if;
  import g2fb_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] pixel_value;
  logic              inside_res;

  modport source (output valid, pixel_value, inside_res, input ready);
  modport sink   (input valid, pixel_value, inside_res, output ready);
endinterface

/* rtl/g2fb_ram.sv */
// Single-port-write, single-port-read frame store with registered read data.
`timescale 1ns / 1ps

module g2fb_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [g2fb_pkg::ADDR_W-1:0] waddr,
  input  logic [g2fb_pkg::WORD_W-1:0] wdata,
  input  logic [g2fb_pkg::ADDR_W-1:0] raddr,
  output logic [g2fb_pkg::WORD_W-1:0] rdata
);
  import g2fb_pkg::*;

  logic [WORD_W-1:0] mem [STORE_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/gray2_framebuffer_pixel_engine.sv */
// Top level of the 2-bit grayscale frame store engine: command sequencer around the store.
`timescale 1ns / 1ps

// The block keeps a frame of 2-bit gray pixels, eight to a 16-bit word, and executes one
// command per transfer on the in_cmd channel: write pixel, read pixel, fill rectangle or
// clear frame. Each command gives exactly one transfer on the out_res channel, carrying
// the pixel read (zero otherwise) and whether the single addressed pixel is on screen.
// Off-screen pixels are clipped; a read off screen returns zero.
// Commands are executed one at a time; in_cmd.ready is high only while the engine is idle.
// Write and read pixel each do the store read, then the masked write back and the result
// register. A fill reads, then merges and writes, each store word that the clipped
// rectangle touches. A clear writes one store word per cycle. All of this is set by the
// single read and single write port of the store.
// After reset the engine sweeps all 1980 store words to zero, with in_cmd.ready low.
// The result sits in an output register; when the receiver stalls, the engine still takes
// the next command and only holds back its completion until that register is free.

module gray2_framebuffer_pixel_engine (
  input logic         clk,
  input logic         rst_n,
  g2fb_cmd_if.sink    in_cmd,
  g2fb_res_if.source  out_res
);
  import g2fb_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PIX   = 6'b000100,
    ST_FRD   = 6'b001000,
    ST_FWR   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [PSEL_W-1:0]   shift_r, shift_nxt;
  logic [GRAY_W-1:0]   code_r, code_nxt;
  logic                is_write_r, is_write_nxt;
  logic                inside_r, inside_nxt;
  logic [WX_W-1:0]     x0w_r, x0w_nxt;
  logic [WX_W-1:0]     x1w_r, x1w_nxt;
  logic [WX_W-1:0]     wx_r, wx_nxt;
  logic [PSEL_W-1:0]   lo_r, lo_nxt;
  logic [PSEL_W-1:0]   hi_r, hi_nxt;
  logic [ROW_W-1:0]    y_r, y_nxt;
  logic [ROW_W-1:0]    y1_r, y1_nxt;
  logic [IDX_W-1:0]    rowbase_r, rowbase_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                clr_cmd_r, clr_cmd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [GRAY_W-1:0]   out_pix_r, out_pix_nxt;
  logic                out_inside_r, out_inside_nxt;

  // Store ports.
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [WORD_W-1:0]   wdata;
  logic [ADDR_W-1:0]   raddr;
  logic [WORD_W-1:0]   rdata;

  // Command decode.
  opcode_t                  op_in;
  logic signed [COORD_W-1:0] x_in, y_in;
  logic signed [EXT_W-1:0]  x_ext, y_ext;
  logic signed [EXT_W-1:0]  x_lo, y_lo, x_hi_raw, y_hi_raw, x_hi, y_hi;
  logic                     fill_empty;
  logic [ROW_W-1:0]         y_sel;
  logic [IDX_W-1:0]         row_base;
  logic [IDX_W-1:0]         pix_idx;
  logic                     pix_on;

  // Datapath helpers.
  logic [IDX_W-1:0]         faddr;
  logic                     faddr_ok;
  logic [WORD_W-1:0]        fmask;
  logic [WORD_W-1:0]        fpattern;
  logic [WORD_W-1:0]        pmask;
  logic [WORD_W-1:0]        pdata;
  logic [WORD_W-1:0]        rd_shift;
  logic                     slot_free;
  logic                     in_fire;

  g2fb_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Decode and clip the incoming command.
  always_comb begin
    op_in    = opcode_t'(in_cmd.opcode);
    x_in     = in_cmd.pos_x;
    y_in     = in_cmd.pos_y;
    x_ext    = EXT_W'(x_in);
    y_ext    = EXT_W'(y_in);
    x_lo     = x_ext[EXT_W-1] ? '0 : x_ext;
    y_lo     = y_ext[EXT_W-1] ? '0 : y_ext;
    x_hi_raw = x_ext + $signed(EXT_W'(in_cmd.box_width)) - EXT_W'(1);
    y_hi_raw = y_ext + $signed(EXT_W'(in_cmd.box_height)) - EXT_W'(1);
    x_hi     = (x_hi_raw > COL_MAX) ? COL_MAX : x_hi_raw;
    y_hi     = (y_hi_raw > ROW_MAX) ? ROW_MAX : y_hi_raw;
    fill_empty = (x_lo > x_hi) || (y_lo > y_hi);
    // One row multiplier serves both the pixel address and the first fill row.
    y_sel    = (op_in == OP_FILL) ? y_lo[ROW_W-1:0] : y_in[ROW_W-1:0];
    row_base = IDX_W'(y_sel) * IDX_W'(WORDS_PER_ROW);
    pix_idx  = row_base + IDX_W'(x_in[COORD_W-1:PSEL_W]);
    pix_on   = !x_in[COORD_W-1] && (x_in < COL_LIM) &&
               !y_in[COORD_W-1] && (y_in < ROW_LIM) &&
               (pix_idx < IDX_W'(STORE_DEPTH));
  end

  // Fill word address and the mask of pixels this word contributes.
  always_comb begin
    logic [PSEL_W-1:0] lo_sel;
    logic [PSEL_W-1:0] hi_sel;
    faddr    = rowbase_r + IDX_W'(wx_r);
    faddr_ok = faddr < IDX_W'(STORE_DEPTH);
    lo_sel   = (wx_r == x0w_r) ? lo_r : '0;
    hi_sel   = (wx_r == x1w_r) ? hi_r : PSEL_W'(PIX_PER_W - 1);
    fmask    = span_mask(lo_sel, hi_sel);
    fpattern = {PIX_PER_W{code_r}};
  end

  // Single pixel masks.
  always_comb begin
    pmask    = WORD_W'(2'b11) << {shift_r, 1'b0};
    pdata    = WORD_W'(code_r) << {shift_r, 1'b0};
    rd_shift = rdata >> {shift_r, 1'b0};
  end

  assign slot_free = !out_valid_r || out_res.ready;
  assign in_fire   = in_cmd.valid && (state_r == ST_IDLE);

  // Read address: the new command in idle, otherwise the word being worked on.
  always_comb begin
    case (state_r)
      ST_IDLE: raddr = pix_idx[ADDR_W-1:0];
      ST_FRD:  raddr = faddr[ADDR_W-1:0];
      default: raddr = addr_r;
    endcase
  end

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    shift_nxt      = shift_r;
    code_nxt       = code_r;
    is_write_nxt   = is_write_r;
    inside_nxt     = inside_r;
    x0w_nxt        = x0w_r;
    x1w_nxt        = x1w_r;
    wx_nxt         = wx_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    y_nxt          = y_r;
    y1_nxt         = y1_r;
    rowbase_nxt    = rowbase_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_cmd_nxt    = clr_cmd_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_pix_nxt    = out_pix_r;
    out_inside_nxt = out_inside_r;
    we             = 1'b0;
    waddr          = addr_r;
    wdata          = '0;

    case (state_r)
      // Zero sweep after reset or for a clear command.
      ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          code_nxt = in_cmd.gray_level;
          case (op_in)
            OP_WRITE, OP_READ: begin
              addr_nxt     = pix_idx[ADDR_W-1:0];
              shift_nxt    = x_in[PSEL_W-1:0];
              is_write_nxt = (op_in == OP_WRITE);
              inside_nxt   = pix_on;
              state_nxt    = ST_PIX;
            end
            OP_FILL: begin
              x0w_nxt     = x_lo[SPAN_W-1:PSEL_W];
              x1w_nxt     = x_hi[SPAN_W-1:PSEL_W];
              wx_nxt      = x_lo[SPAN_W-1:PSEL_W];
              lo_nxt      = x_lo[PSEL_W-1:0];
              hi_nxt      = x_hi[PSEL_W-1:0];
              y_nxt       = y_lo[ROW_W-1:0];
              y1_nxt      = y_hi[ROW_W-1:0];
              rowbase_nxt = row_base;
              state_nxt   = fill_empty ? ST_DONE : ST_FRD;
            end
            default: begin
              clr_cnt_nxt = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
          endcase
        end
      end

      // Read data is back: merge or extract, and complete once the result slot is free.
      ST_PIX: begin
        if (slot_free) begin
          if (is_write_r && inside_r) begin
            we    = 1'b1;
            waddr = addr_r;
            wdata = (rdata & ~pmask) | pdata;
          end
          out_valid_nxt  = 1'b1;
          out_pix_nxt    = (!is_write_r && inside_r) ? rd_shift[GRAY_W-1:0] : '0;
          out_inside_nxt = inside_r;
          state_nxt      = ST_IDLE;
        end
      end

      ST_FRD: begin
        state_nxt = ST_FWR;
      end

      // Merge the fill pattern into the word and step to the next word or row.
      ST_FWR: begin
        we    = faddr_ok;
        waddr = faddr[ADDR_W-1:0];
        wdata = (rdata & ~fmask) | (fpattern & fmask);
        if (wx_r == x1w_r) begin
          if (y_r == y1_r) begin
            state_nxt = ST_DONE;
          end else begin
            y_nxt       = y_r + ROW_W'(1);
            rowbase_nxt = rowbase_r + IDX_W'(WORDS_PER_ROW);
            wx_nxt      = x0w_r;
            state_nxt   = ST_FRD;
          end
        end else begin
          wx_nxt    = wx_r + WX_W'(1);
          state_nxt = ST_FRD;
        end
      end

      // Fill and clear report a fixed result.
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_pix_nxt    = '0;
          out_inside_nxt = 1'b0;
          clr_cmd_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    shift_r      <= shift_nxt;
    code_r       <= code_nxt;
    is_write_r   <= is_write_nxt;
    inside_r     <= inside_nxt;
    x0w_r        <= x0w_nxt;
    x1w_r        <= x1w_nxt;
    wx_r         <= wx_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    y_r          <= y_nxt;
    y1_r         <= y1_nxt;
    rowbase_r    <= rowbase_nxt;
    out_pix_r    <= out_pix_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign in_cmd.ready       = (state_r == ST_IDLE);
  assign out_res.valid      = out_valid_r;
  assign out_res.pixel_value = out_pix_r;
  assign out_res.inside_res = out_inside_r;
endmodule

/* rtl/g2fb_checker.sv */
// Port-level checks of the frame store engine and their attachment to the top level.
`timescale 1ns / 1ps

module g2fb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [g2fb_pkg::GRAY_W-1:0] out_pixel_value,
  input logic                        out_inside_res
);
  import g2fb_pkg::*;

  // A result waiting for the receiver stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // The zero sweep after reset keeps commands out.
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command channel ready during reset sweep");

  // Commands run one at a time: no transfer in the cycle after one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in progress");

  // A nonzero pixel can only come from an on-screen read.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pixel_value != '0) |-> out_inside_res)
    else $error("pixel value reported for an off-screen access");
endmodule

bind gray2_framebuffer_pixel_engine g2fb_checker u_g2fb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_cmd.valid),
  .in_ready        (in_cmd.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_pixel_value (out_res.pixel_value),
  .out_inside_res  (out_res.inside_res)
);
